// ===== hw/rtl/motor_feedback_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// motor_feedback_tracker_defines.svh
// Assertion macros used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mft: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mft: next-cycle check failed");

`endif

// ===== hw/rtl/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// mft_pkg
// Types and constants for the motor feedback tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mft_pkg;

   localparam int CURRENT_W = 16;
   localparam int COUNT_W   = 16;
   localparam int ANGLE_W   = 13;
   localparam int TEMP_W    = 8;
   localparam int SUM_W     = 32;
   localparam int CHANGE_W  = 14;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
   localparam logic [COUNT_W-1:0] STALL_LIMIT_RESET = 16'd100;
   localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RESET  = 8'd70;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STALL_FRAME_LIMIT = 8'd0,
      CSR_TEMPERATURE_LIMIT = 8'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      LINK_FINE         = 2'd0,
      LINK_UNCONNECTED  = 2'd1,
      LINK_DISCONNECTED = 2'd2
   } link_status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      link_status_type    status;
   } link_update_type;

endpackage

// ===== hw/rtl/mft_link.sv =====
// ----------------------------------------------------------------------------
// mft_link
// Link supervisor: repeated-current frame count and link status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_link (
   input  logic [mft_pkg::CURRENT_W-1:0] current,
   input  logic [mft_pkg::CURRENT_W-1:0] previous_current,
   input  logic [mft_pkg::COUNT_W-1:0]   repeat_count,
   input  logic [mft_pkg::COUNT_W-1:0]   stall_frame_limit,
   output mft_pkg::link_update_type      update
);

   logic [mft_pkg::COUNT_W-1:0] count_bumped;

   always_comb begin
      if (current == previous_current) begin
         if (repeat_count == mft_pkg::COUNT_MAX) begin
            count_bumped = repeat_count;
         end else begin
            count_bumped = repeat_count + 1'b1;
         end
      end else begin
         count_bumped = '0;
      end

      // Count at or past the limit: clamp it and report the link as lost.
      if (count_bumped >= stall_frame_limit) begin
         update.count = stall_frame_limit;
         if (previous_current == '0) begin
            update.status = mft_pkg::LINK_UNCONNECTED;
         end else begin
            update.status = mft_pkg::LINK_DISCONNECTED;
         end
      end else begin
         update.count  = count_bumped;
         update.status = mft_pkg::LINK_FINE;
      end
   end

endmodule

// ===== hw/rtl/motor_feedback_tracker.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_tracker
// Motor feedback frame decoder with multi-turn angle and link supervision.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Payload
// req_      in   req_tvalid/req_tready   feedback frame bytes (req_tdata)
// rsp_      out  rsp_tvalid/rsp_tready   decoded words and status (rsp_tdata)
// csr_      in   csr_valid/csr_ready     register index and write data
//
// Throughput: one item per cycle while rsp_tready stays high; an accepted item
//   passes the input register, then the result register, before it leaves.
// The per-item work is one 15-bit subtract with a wrap correction, a 32-bit
//   add and a 16-bit compare chain, all between those two registers.
// Reset: synchronous, clears the tracking state and restores the register
//   reset values (stall limit 100, temperature limit 70).
// Stalls: a held result blocks the input register only; the input register
//   still refills in the cycle the result is taken. csr_ready is always high.
//
`timescale 1ns / 1ps
`include "motor_feedback_tracker_defines.svh"

module motor_feedback_tracker #(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] angle_high, [12:5] angle_low, [20:13] speed_high,
   // [28:21] speed_low, [36:29] current_high, [44:37] current_low,
   // [52:45] temperature, [55:53] zero
   input  logic [55:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] motor_current, [31:16] speed_rpm, [45:32] angle_change,
   // [77:46] total_angle, [79:78] link_status, [80] over_temperature,
   // [87:81] zero
   output logic [87:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mft_pkg::CSR_DAT_W-1:0] csr_wdata
);

   // Wrap arithmetic needs room for a full turn plus sign, and for the raw
   // 13-bit angle difference.
   localparam int TURN_BITS = $clog2(COUNTS_PER_TURN) + 2;
   localparam int DELTA_W   = (TURN_BITS > mft_pkg::ANGLE_W + 2) ?
                              TURN_BITS : mft_pkg::ANGLE_W + 2;
   localparam logic signed [DELTA_W-1:0] TURN = DELTA_W'(COUNTS_PER_TURN);
   localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'(COUNTS_PER_TURN / 2);

   // ---------------- configuration registers ----------------
   logic [mft_pkg::COUNT_W-1:0] stall_limit_ff;
   logic [mft_pkg::TEMP_W-1:0]  temp_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_limit_ff <= mft_pkg::STALL_LIMIT_RESET;
         temp_limit_ff  <= mft_pkg::TEMP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mft_pkg::CSR_STALL_FRAME_LIMIT: begin
               stall_limit_ff <= csr_wdata;
            end
            mft_pkg::CSR_TEMPERATURE_LIMIT: begin
               temp_limit_ff <= csr_wdata[mft_pkg::TEMP_W-1:0];
            end
            default: begin
               // unmapped index: write ignored
            end
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                          s1_valid_ff;
   logic [mft_pkg::ANGLE_W-1:0]   s1_angle_ff;
   logic [mft_pkg::CURRENT_W-1:0] s1_speed_ff;
   logic [mft_pkg::CURRENT_W-1:0] s1_current_ff;
   logic [mft_pkg::TEMP_W-1:0]    s1_temp_ff;
   logic                          advance;
   logic                          req_take;

   // Item moves to the result register when that register is empty or drains.
   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_angle_ff   <= {req_tdata[4:0], req_tdata[12:5]};
         s1_speed_ff   <= {req_tdata[20:13], req_tdata[28:21]};
         s1_current_ff <= {req_tdata[36:29], req_tdata[44:37]};
         s1_temp_ff    <= req_tdata[52:45];
      end
   end

   // ---------------- tracking state ----------------
   logic [mft_pkg::ANGLE_W-1:0]   prev_angle_ff;
   logic [mft_pkg::CURRENT_W-1:0] prev_current_ff;
   logic [mft_pkg::COUNT_W-1:0]   repeat_count_ff;
   logic [mft_pkg::SUM_W-1:0]     angle_sum_ff;
   logic [mft_pkg::SUM_W-1:0]     angle_sum_in;
   mft_pkg::link_update_type      link_update;

   mft_link u_link (
      .current           (s1_current_ff),
      .previous_current  (prev_current_ff),
      .repeat_count      (repeat_count_ff),
      .stall_frame_limit (stall_limit_ff),
      .update            (link_update)
   );

   // Angle change wrapped into plus or minus half a turn.
   logic signed [DELTA_W-1:0] delta_raw;
   logic signed [DELTA_W-1:0] delta;

   always_comb begin
      delta_raw = $signed({{(DELTA_W - mft_pkg::ANGLE_W){1'b0}}, s1_angle_ff})
                - $signed({{(DELTA_W - mft_pkg::ANGLE_W){1'b0}}, prev_angle_ff});
      if (delta_raw > HALF) begin
         delta = delta_raw - TURN;
      end else if (delta_raw < -HALF) begin
         delta = delta_raw + TURN;
      end else begin
         delta = delta_raw;
      end
      angle_sum_in = angle_sum_ff
                   + {{(mft_pkg::SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff   <= '0;
         prev_current_ff <= '0;
         repeat_count_ff <= '0;
         angle_sum_ff    <= '0;
      end else if (advance) begin
         prev_angle_ff   <= s1_angle_ff;
         prev_current_ff <= s1_current_ff;
         repeat_count_ff <= link_update.count;
         angle_sum_ff    <= angle_sum_in;
      end
   end

   // ---------------- result register ----------------
   logic                            rsp_valid_ff;
   logic [mft_pkg::CURRENT_W-1:0]   rsp_current_ff;
   logic [mft_pkg::CURRENT_W-1:0]   rsp_speed_ff;
   logic [mft_pkg::CHANGE_W-1:0]    rsp_change_ff;
   logic [mft_pkg::SUM_W-1:0]       rsp_total_ff;
   mft_pkg::link_status_type        rsp_status_ff;
   logic                            rsp_over_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_current_ff   <= s1_current_ff;
         rsp_speed_ff     <= s1_speed_ff;
         rsp_change_ff    <= delta[mft_pkg::CHANGE_W-1:0];
         rsp_total_ff     <= angle_sum_in;
         rsp_status_ff    <= link_update.status;
         rsp_over_temp_ff <= (s1_temp_ff > temp_limit_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_over_temp_ff, rsp_status_ff, rsp_total_ff,
                        rsp_change_ff, rsp_speed_ff, rsp_current_ff};

   // ---------------- checks ----------------
   // A new item never lands on a held one.
   `MFT_ASSERT_NOW(a_no_overwrite, clock, reset, req_take && s1_valid_ff, advance)
   // Every advanced item shows up as a result.
   `MFT_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_tvalid)
   // The stored angle is the one of the item just processed.
   `MFT_ASSERT_NEXT(a_prev_angle, clock, reset, advance,
                    prev_angle_ff == $past(s1_angle_ff))

endmodule
